// File: hw/rtl/particle_euler_step_assert.svh
// particle_euler_step_assert.svh: assertion macros shared by the particle euler step rtl
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef PARTICLE_EULER_STEP_ASSERT_SVH
`define PARTICLE_EULER_STEP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled while reset is active
`define PES_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication, active during reset too
`define PES_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PES_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PES_ASSERT_NEXT(label, clk, ante, cons)
`endif
`endif

// File: hw/rtl/pes_pkg.sv
// pes_pkg.sv: shared widths, register indexes and sideband types for particle_euler_step
// no dependencies
`default_nettype none

package pes_pkg;

    // register indexes of the configuration port
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_TIME_STEP      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FLOOR_LEVEL    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_BOUNCE_DAMPING = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT    = 3'd3;

    // register widths and reset values
    localparam int TimeW = 16;
    localparam int DampW = 16;
    localparam int LimW  = 31;
    localparam int MassW = 16;
    localparam logic [TimeW-1:0]  TIME_STEP_RST      = 16'd655;
    localparam logic [31:0]       FLOOR_LEVEL_RST    = 32'd39256064;
    localparam logic [DampW-1:0]  BOUNCE_DAMPING_RST = 16'd13107;
    localparam logic [LimW-1:0]   SPEED_LIMIT_RST    = 31'd65536000;

    // divider and square root widths
    localparam int FdivNumW  = 39;
    localparam int FdivDenW  = 16;
    localparam int SqrtInW   = 64;
    localparam int SqrtOutW  = 32;
    localparam int LprodW    = 62;
    localparam int LimSqW    = 62;
    localparam int LdivNumW  = 31;
    localparam int LdivDenW  = 32;

    typedef logic signed [31:0] word_t;

    // sideband through the force divider
    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t vel_x;
        word_t vel_y;
        logic  pinned;
        logic  neg_x;
        logic  neg_y;
    } fdiv_side_t;

    // sideband through the square root
    typedef struct packed {
        word_t             pos_x;
        word_t             pos_y;
        word_t             vel_x;
        word_t             vel_y;
        logic [LprodW-1:0] lim_x;
        logic [LprodW-1:0] lim_y;
        logic              neg_x;
        logic              neg_y;
        logic              pinned;
        logic              hit;
    } sqrt_side_t;

    // sideband through the limit divider
    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t vel_x;
        word_t vel_y;
        logic  neg_x;
        logic  neg_y;
        logic  pinned;
        logic  hit;
        logic  limited;
    } ldiv_side_t;

endpackage

`default_nettype wire

// File: hw/rtl/pes_fdiv.sv
// pes_fdiv.sv: pipelined restoring divider for force * time step / mass, two lanes
// depends on pes_pkg
`default_nettype none

module pes_fdiv (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [pes_pkg::FdivNumW-1:0]  in_num_x,
    input  wire logic [pes_pkg::FdivNumW-1:0]  in_num_y,
    input  wire logic [pes_pkg::FdivDenW-1:0]  in_den,
    input  wire pes_pkg::fdiv_side_t           in_side,
    output logic                               out_valid,
    output logic [pes_pkg::FdivNumW-1:0]       out_quo_x,
    output logic [pes_pkg::FdivNumW-1:0]       out_quo_y,
    output pes_pkg::fdiv_side_t                out_side
);

    localparam int NumW  = pes_pkg::FdivNumW;
    localparam int DenW  = pes_pkg::FdivDenW;
    localparam int WorkW = NumW + DenW;

    // one quotient bit per stage: {remainder, dividend bits / quotient bits}
    function automatic logic [WorkW-1:0] div_step(input logic [WorkW-1:0] w,
                                                  input logic [DenW-1:0]  d);
        logic [DenW:0] cand;
        logic [DenW:0] diff;
        cand = w[WorkW-1:NumW-1];
        diff = cand - {1'b0, d};
        if (cand >= {1'b0, d}) begin
            return {diff[DenW-1:0], w[NumW-2:0], 1'b1};
        end
        return {cand[DenW-1:0], w[NumW-2:0], 1'b0};
    endfunction

    logic [NumW:0]        valid_reg;
    logic [WorkW-1:0]     work_x_reg [0:NumW];
    logic [WorkW-1:0]     work_y_reg [0:NumW];
    logic [DenW-1:0]      den_reg    [0:NumW];
    pes_pkg::fdiv_side_t  side_reg   [0:NumW];

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NumW-1:0], in_valid};
        end
    end

    // divider stages
    always_ff @(posedge aclk) begin
        if (en) begin
            work_x_reg[0] <= {{DenW{1'b0}}, in_num_x};
            work_y_reg[0] <= {{DenW{1'b0}}, in_num_y};
            den_reg[0]    <= in_den;
            side_reg[0]   <= in_side;
            for (int k = 0; k < NumW; k++) begin
                work_x_reg[k+1] <= div_step(work_x_reg[k], den_reg[k]);
                work_y_reg[k+1] <= div_step(work_y_reg[k], den_reg[k]);
                den_reg[k+1]    <= den_reg[k];
                side_reg[k+1]   <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[NumW];
    assign out_quo_x = work_x_reg[NumW][NumW-1:0];
    assign out_quo_y = work_y_reg[NumW][NumW-1:0];
    assign out_side  = side_reg[NumW];

endmodule

`default_nettype wire

// File: hw/rtl/pes_motion.sv
// pes_motion.sv: velocity and position update, floor bounce, squares and limit products
// depends on pes_pkg
`default_nettype none

module pes_motion (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [pes_pkg::TimeW-1:0]     time_step,
    input  wire pes_pkg::word_t                floor_level,
    input  wire logic [pes_pkg::DampW-1:0]     bounce_damping,
    input  wire logic [pes_pkg::LimW-1:0]      speed_limit,
    input  wire logic                          in_valid,
    input  wire logic [pes_pkg::FdivNumW-1:0]  in_quo_x,
    input  wire logic [pes_pkg::FdivNumW-1:0]  in_quo_y,
    input  wire pes_pkg::fdiv_side_t           in_side,
    output logic                               out_valid,
    output logic [pes_pkg::SqrtInW-1:0]        out_mag2,
    output logic [pes_pkg::LimSqW-1:0]         out_lim2,
    output pes_pkg::sqrt_side_t                out_side
);

    function automatic pes_pkg::word_t sat32(input logic signed [41:0] x);
        if (x > 42'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (x < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    logic [8:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[7:0], in_valid};
        end
    end

    // stage 0: velocity gains the force term
    logic signed [41:0] dv_x, dv_y, vsum_x, vsum_y;
    assign dv_x   = in_side.neg_x ? -$signed({3'b000, in_quo_x}) : $signed({3'b000, in_quo_x});
    assign dv_y   = in_side.neg_y ? -$signed({3'b000, in_quo_y}) : $signed({3'b000, in_quo_y});
    assign vsum_x = 42'(in_side.vel_x) + dv_x;
    assign vsum_y = 42'(in_side.vel_y) + dv_y;

    pes_pkg::word_t st0_pos_x_reg, st0_pos_y_reg, st0_vel_x_reg, st0_vel_y_reg;
    logic           st0_pinned_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st0_pos_x_reg  <= in_side.pos_x;
            st0_pos_y_reg  <= in_side.pos_y;
            st0_vel_x_reg  <= in_side.pinned ? in_side.vel_x : sat32(vsum_x);
            st0_vel_y_reg  <= in_side.pinned ? in_side.vel_y : sat32(vsum_y);
            st0_pinned_reg <= in_side.pinned;
        end
    end

    // stage 1: velocity times time step
    logic signed [48:0] tprod_x, tprod_y;
    assign tprod_x = st0_vel_x_reg * $signed({1'b0, time_step});
    assign tprod_y = st0_vel_y_reg * $signed({1'b0, time_step});

    logic signed [47:0] st1_prod_x_reg, st1_prod_y_reg;
    pes_pkg::word_t     st1_pos_x_reg, st1_pos_y_reg, st1_vel_x_reg, st1_vel_y_reg;
    logic               st1_pinned_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_prod_x_reg <= tprod_x[47:0];
            st1_prod_y_reg <= tprod_y[47:0];
            st1_pos_x_reg  <= st0_pos_x_reg;
            st1_pos_y_reg  <= st0_pos_y_reg;
            st1_vel_x_reg  <= st0_vel_x_reg;
            st1_vel_y_reg  <= st0_vel_y_reg;
            st1_pinned_reg <= st0_pinned_reg;
        end
    end

    // stage 2: position gains the truncated step
    logic signed [47:0] pbias_x, pbias_y, pshift_x, pshift_y;
    assign pbias_x  = st1_prod_x_reg + (st1_prod_x_reg[47] ? 48'sd65535 : 48'sd0);
    assign pbias_y  = st1_prod_y_reg + (st1_prod_y_reg[47] ? 48'sd65535 : 48'sd0);
    assign pshift_x = pbias_x >>> 16;
    assign pshift_y = pbias_y >>> 16;

    pes_pkg::word_t st2_pos_x_reg, st2_pos_y_reg, st2_vel_x_reg, st2_vel_y_reg;
    logic           st2_pinned_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st2_pos_x_reg  <= st1_pinned_reg ? st1_pos_x_reg
                            : sat32(42'(st1_pos_x_reg) + 42'(pshift_x));
            st2_pos_y_reg  <= st1_pinned_reg ? st1_pos_y_reg
                            : sat32(42'(st1_pos_y_reg) + 42'(pshift_y));
            st2_vel_x_reg  <= st1_vel_x_reg;
            st2_vel_y_reg  <= st1_vel_y_reg;
            st2_pinned_reg <= st1_pinned_reg;
        end
    end

    // stage 3: floor contact, clamp and upward velocity
    logic hit;
    assign hit = !st2_pinned_reg && (st2_pos_y_reg > floor_level);

    pes_pkg::word_t st3_pos_x_reg, st3_pos_y_reg, st3_vel_x_reg, st3_vel_y_reg;
    logic           st3_pinned_reg, st3_hit_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st3_pos_x_reg  <= st2_pos_x_reg;
            st3_pos_y_reg  <= hit ? floor_level : st2_pos_y_reg;
            st3_vel_x_reg  <= st2_vel_x_reg;
            st3_vel_y_reg  <= (hit && (st2_vel_y_reg > 0)) ? -st2_vel_y_reg : st2_vel_y_reg;
            st3_pinned_reg <= st2_pinned_reg;
            st3_hit_reg    <= hit;
        end
    end

    // stage 4: damping products
    logic signed [48:0] dprod_x, dprod_y;
    assign dprod_x = st3_vel_x_reg * $signed({1'b0, bounce_damping});
    assign dprod_y = st3_vel_y_reg * $signed({1'b0, bounce_damping});

    logic signed [47:0] st4_damp_x_reg, st4_damp_y_reg;
    pes_pkg::word_t     st4_pos_x_reg, st4_pos_y_reg, st4_vel_x_reg, st4_vel_y_reg;
    logic               st4_pinned_reg, st4_hit_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st4_damp_x_reg <= dprod_x[47:0];
            st4_damp_y_reg <= dprod_y[47:0];
            st4_pos_x_reg  <= st3_pos_x_reg;
            st4_pos_y_reg  <= st3_pos_y_reg;
            st4_vel_x_reg  <= st3_vel_x_reg;
            st4_vel_y_reg  <= st3_vel_y_reg;
            st4_pinned_reg <= st3_pinned_reg;
            st4_hit_reg    <= st3_hit_reg;
        end
    end

    // stage 5: truncated damped velocity on contact
    logic signed [47:0] dbias_x, dbias_y, dshift_x, dshift_y;
    assign dbias_x  = st4_damp_x_reg + (st4_damp_x_reg[47] ? 48'sd65535 : 48'sd0);
    assign dbias_y  = st4_damp_y_reg + (st4_damp_y_reg[47] ? 48'sd65535 : 48'sd0);
    assign dshift_x = dbias_x >>> 16;
    assign dshift_y = dbias_y >>> 16;

    pes_pkg::word_t st5_pos_x_reg, st5_pos_y_reg, st5_vel_x_reg, st5_vel_y_reg;
    logic           st5_pinned_reg, st5_hit_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st5_pos_x_reg  <= st4_pos_x_reg;
            st5_pos_y_reg  <= st4_pos_y_reg;
            st5_vel_x_reg  <= st4_hit_reg ? dshift_x[31:0] : st4_vel_x_reg;
            st5_vel_y_reg  <= st4_hit_reg ? dshift_y[31:0] : st4_vel_y_reg;
            st5_pinned_reg <= st4_pinned_reg;
            st5_hit_reg    <= st4_hit_reg;
        end
    end

    // stage 6: velocity magnitudes
    logic [31:0]    st6_abs_x_reg, st6_abs_y_reg;
    pes_pkg::word_t st6_pos_x_reg, st6_pos_y_reg, st6_vel_x_reg, st6_vel_y_reg;
    logic           st6_pinned_reg, st6_hit_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st6_abs_x_reg  <= st5_vel_x_reg[31] ? (~st5_vel_x_reg + 32'd1) : st5_vel_x_reg;
            st6_abs_y_reg  <= st5_vel_y_reg[31] ? (~st5_vel_y_reg + 32'd1) : st5_vel_y_reg;
            st6_pos_x_reg  <= st5_pos_x_reg;
            st6_pos_y_reg  <= st5_pos_y_reg;
            st6_vel_x_reg  <= st5_vel_x_reg;
            st6_vel_y_reg  <= st5_vel_y_reg;
            st6_pinned_reg <= st5_pinned_reg;
            st6_hit_reg    <= st5_hit_reg;
        end
    end

    // stage 7: squares and limit products
    logic [63:0]                 sq_x, sq_y;
    logic [62:0]                 lp_x, lp_y;
    logic [pes_pkg::LimSqW-1:0]  lim_sq;
    assign sq_x   = st6_abs_x_reg * st6_abs_x_reg;
    assign sq_y   = st6_abs_y_reg * st6_abs_y_reg;
    assign lp_x   = st6_abs_x_reg * speed_limit;
    assign lp_y   = st6_abs_y_reg * speed_limit;
    assign lim_sq = speed_limit * speed_limit;

    logic [63:0]                 st7_sq_x_reg, st7_sq_y_reg;
    logic [pes_pkg::LimSqW-1:0]  st7_lim2_reg;
    pes_pkg::sqrt_side_t         st7_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st7_sq_x_reg        <= sq_x;
            st7_sq_y_reg        <= sq_y;
            st7_lim2_reg        <= lim_sq;
            st7_side_reg.pos_x  <= st6_pos_x_reg;
            st7_side_reg.pos_y  <= st6_pos_y_reg;
            st7_side_reg.vel_x  <= st6_vel_x_reg;
            st7_side_reg.vel_y  <= st6_vel_y_reg;
            st7_side_reg.lim_x  <= lp_x[pes_pkg::LprodW-1:0];
            st7_side_reg.lim_y  <= lp_y[pes_pkg::LprodW-1:0];
            st7_side_reg.neg_x  <= st6_vel_x_reg[31];
            st7_side_reg.neg_y  <= st6_vel_y_reg[31];
            st7_side_reg.pinned <= st6_pinned_reg;
            st7_side_reg.hit    <= st6_hit_reg;
        end
    end

    // stage 8: squared magnitude
    logic [pes_pkg::SqrtInW-1:0] st8_mag2_reg;
    logic [pes_pkg::LimSqW-1:0]  st8_lim2_reg;
    pes_pkg::sqrt_side_t         st8_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st8_mag2_reg <= st7_sq_x_reg + st7_sq_y_reg;
            st8_lim2_reg <= st7_lim2_reg;
            st8_side_reg <= st7_side_reg;
        end
    end

    assign out_valid = valid_reg[8];
    assign out_mag2  = st8_mag2_reg;
    assign out_lim2  = st8_lim2_reg;
    assign out_side  = st8_side_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pes_isqrt.sv
// pes_isqrt.sv: pipelined integer square root of the squared speed, one root bit per stage
// depends on pes_pkg
`default_nettype none

module pes_isqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [pes_pkg::SqrtInW-1:0]   in_mag2,
    input  wire logic [pes_pkg::LimSqW-1:0]    in_lim2,
    input  wire pes_pkg::sqrt_side_t           in_side,
    output logic                               out_valid,
    output logic [pes_pkg::SqrtOutW-1:0]       out_root,
    output logic                               out_limited,
    output pes_pkg::sqrt_side_t                out_side
);

    localparam int InW   = pes_pkg::SqrtInW;
    localparam int RootW = pes_pkg::SqrtOutW;
    localparam int RemW  = RootW + 2;
    localparam int WorkW = RemW + InW;

    // one root digit: bring in two bits, try 4 * root + 1
    function automatic logic [WorkW+RootW-1:0] sqrt_step(input logic [WorkW-1:0] w,
                                                         input logic [RootW-1:0] r);
        logic [RemW+1:0] r4;
        logic [RemW+1:0] trial;
        logic [RemW+1:0] diff;
        r4    = w[WorkW-1:InW-2];
        trial = {2'b00, r, 2'b01};
        diff  = r4 - trial;
        if (r4 >= trial) begin
            return {diff[RemW-1:0], w[InW-3:0], 2'b00, r[RootW-2:0], 1'b1};
        end
        return {r4[RemW-1:0], w[InW-3:0], 2'b00, r[RootW-2:0], 1'b0};
    endfunction

    logic [RootW:0]       valid_reg;
    logic [WorkW-1:0]     work_reg    [0:RootW];
    logic [RootW-1:0]     root_reg    [0:RootW];
    logic                 limited_reg [0:RootW];
    pes_pkg::sqrt_side_t  side_reg    [0:RootW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[RootW-1:0], in_valid};
        end
    end

    // root stages; the limit test rides along
    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg[0]    <= {{RemW{1'b0}}, in_mag2};
            root_reg[0]    <= '0;
            limited_reg[0] <= !in_side.pinned && (in_mag2 > {2'b00, in_lim2});
            side_reg[0]    <= in_side;
            for (int k = 0; k < RootW; k++) begin
                {work_reg[k+1], root_reg[k+1]} <= sqrt_step(work_reg[k], root_reg[k]);
                limited_reg[k+1] <= limited_reg[k];
                side_reg[k+1]    <= side_reg[k];
            end
        end
    end

    assign out_valid   = valid_reg[RootW];
    assign out_root    = root_reg[RootW];
    assign out_limited = limited_reg[RootW];
    assign out_side    = side_reg[RootW];

endmodule

`default_nettype wire

// File: hw/rtl/pes_ldiv.sv
// pes_ldiv.sv: pipelined divider for |v| * speed_limit / root, two lanes, 31 quotient bits
// depends on pes_pkg
`default_nettype none

module pes_ldiv (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [pes_pkg::SqrtOutW-1:0]  in_root,
    input  wire logic                          in_limited,
    input  wire pes_pkg::sqrt_side_t           in_side,
    output logic                               out_valid,
    output logic [pes_pkg::LdivNumW-1:0]       out_quo_x,
    output logic [pes_pkg::LdivNumW-1:0]       out_quo_y,
    output pes_pkg::ldiv_side_t                out_side
);

    localparam int NumW  = pes_pkg::LdivNumW;
    localparam int DenW  = pes_pkg::LdivDenW;
    localparam int WorkW = NumW + DenW;
    localparam int HiW   = pes_pkg::LprodW - NumW;

    // the quotient stays below 2^31 when limited, so the upper dividend bits start
    // out as the remainder
    function automatic logic [WorkW-1:0] div_step(input logic [WorkW-1:0] w,
                                                  input logic [DenW-1:0]  d);
        logic [DenW:0] cand;
        logic [DenW:0] diff;
        cand = w[WorkW-1:NumW-1];
        diff = cand - {1'b0, d};
        if (cand >= {1'b0, d}) begin
            return {diff[DenW-1:0], w[NumW-2:0], 1'b1};
        end
        return {cand[DenW-1:0], w[NumW-2:0], 1'b0};
    endfunction

    logic [NumW:0]        valid_reg;
    logic [WorkW-1:0]     work_x_reg [0:NumW];
    logic [WorkW-1:0]     work_y_reg [0:NumW];
    logic [DenW-1:0]      den_reg    [0:NumW];
    pes_pkg::ldiv_side_t  side_reg   [0:NumW];
    pes_pkg::ldiv_side_t  side_in;

    always_comb begin
        side_in.pos_x   = in_side.pos_x;
        side_in.pos_y   = in_side.pos_y;
        side_in.vel_x   = in_side.vel_x;
        side_in.vel_y   = in_side.vel_y;
        side_in.neg_x   = in_side.neg_x;
        side_in.neg_y   = in_side.neg_y;
        side_in.pinned  = in_side.pinned;
        side_in.hit     = in_side.hit;
        side_in.limited = in_limited;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NumW-1:0], in_valid};
        end
    end

    // divider stages
    always_ff @(posedge aclk) begin
        if (en) begin
            work_x_reg[0] <= {{(DenW-HiW){1'b0}}, in_side.lim_x};
            work_y_reg[0] <= {{(DenW-HiW){1'b0}}, in_side.lim_y};
            den_reg[0]    <= in_root;
            side_reg[0]   <= side_in;
            for (int k = 0; k < NumW; k++) begin
                work_x_reg[k+1] <= div_step(work_x_reg[k], den_reg[k]);
                work_y_reg[k+1] <= div_step(work_y_reg[k], den_reg[k]);
                den_reg[k+1]    <= den_reg[k];
                side_reg[k+1]   <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[NumW];
    assign out_quo_x = work_x_reg[NumW][NumW-1:0];
    assign out_quo_y = work_y_reg[NumW][NumW-1:0];
    assign out_side  = side_reg[NumW];

endmodule

`default_nettype wire

// File: hw/rtl/particle_euler_step.sv
// particle_euler_step: throughput one transaction per cycle unless a result waits on m_ready.
// the whole pipeline advances together and holds as one while a finished result waits
// on m_ready. the length is set by the input registers, the force divider (40 stages),
// the motion stages, the square root (33), the limit divider (32) and the output register.
// reset (synchronous, aresetn low) empties the pipeline and loads the register defaults.
`default_nettype none
`include "particle_euler_step_assert.svh"

module particle_euler_step (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pes_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [31:0]                   cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [31:0]            s_pos_x,
    input  wire logic signed [31:0]            s_pos_y,
    input  wire logic signed [31:0]            s_vel_x,
    input  wire logic signed [31:0]            s_vel_y,
    input  wire logic signed [31:0]            s_force_x,
    input  wire logic signed [31:0]            s_force_y,
    input  wire logic [pes_pkg::MassW-1:0]     s_mass,
    input  wire logic                          s_pinned,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [31:0]                 m_new_pos_x,
    output logic signed [31:0]                 m_new_pos_y,
    output logic signed [31:0]                 m_new_vel_x,
    output logic signed [31:0]                 m_new_vel_y
);

    // configuration registers
    logic [pes_pkg::TimeW-1:0] time_step_reg;
    pes_pkg::word_t            floor_level_reg;
    logic [pes_pkg::DampW-1:0] bounce_damping_reg;
    logic [pes_pkg::LimW-1:0]  speed_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg      <= pes_pkg::TIME_STEP_RST;
            floor_level_reg    <= pes_pkg::FLOOR_LEVEL_RST;
            bounce_damping_reg <= pes_pkg::BOUNCE_DAMPING_RST;
            speed_limit_reg    <= pes_pkg::SPEED_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pes_pkg::REG_TIME_STEP:      time_step_reg      <= cfg_wdata[15:0];
                pes_pkg::REG_FLOOR_LEVEL:    floor_level_reg    <= cfg_wdata;
                pes_pkg::REG_BOUNCE_DAMPING: bounce_damping_reg <= cfg_wdata[15:0];
                pes_pkg::REG_SPEED_LIMIT:    speed_limit_reg    <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // global pipeline advance
    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic f0_valid_reg, f1_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
        end else if (en) begin
            f0_valid_reg <= s_valid;
            f1_valid_reg <= f0_valid_reg;
        end
    end

    // input register; zero mass counts as the smallest mass
    pes_pkg::word_t            f0_pos_x_reg, f0_pos_y_reg, f0_vel_x_reg, f0_vel_y_reg;
    pes_pkg::word_t            f0_force_x_reg, f0_force_y_reg;
    logic [pes_pkg::MassW-1:0] f0_mass_reg;
    logic                      f0_pinned_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f0_pos_x_reg   <= s_pos_x;
            f0_pos_y_reg   <= s_pos_y;
            f0_vel_x_reg   <= s_vel_x;
            f0_vel_y_reg   <= s_vel_y;
            f0_force_x_reg <= s_force_x;
            f0_force_y_reg <= s_force_y;
            f0_mass_reg    <= (s_mass == '0) ? 16'd1 : s_mass;
            f0_pinned_reg  <= s_pinned;
        end
    end

    // force times time step
    logic signed [48:0] fprod_x, fprod_y;
    assign fprod_x = f0_force_x_reg * $signed({1'b0, time_step_reg});
    assign fprod_y = f0_force_y_reg * $signed({1'b0, time_step_reg});

    logic signed [47:0]        f1_prod_x_reg, f1_prod_y_reg;
    pes_pkg::word_t            f1_pos_x_reg, f1_pos_y_reg, f1_vel_x_reg, f1_vel_y_reg;
    logic [pes_pkg::MassW-1:0] f1_mass_reg;
    logic                      f1_pinned_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_prod_x_reg <= fprod_x[47:0];
            f1_prod_y_reg <= fprod_y[47:0];
            f1_pos_x_reg  <= f0_pos_x_reg;
            f1_pos_y_reg  <= f0_pos_y_reg;
            f1_vel_x_reg  <= f0_vel_x_reg;
            f1_vel_y_reg  <= f0_vel_y_reg;
            f1_mass_reg   <= f0_mass_reg;
            f1_pinned_reg <= f0_pinned_reg;
        end
    end

    // magnitude over 256 feeds the divider by mass
    logic [47:0]         fmag_x, fmag_y;
    pes_pkg::fdiv_side_t fdiv_side_in;
    assign fmag_x = f1_prod_x_reg[47] ? (~f1_prod_x_reg + 48'd1) : f1_prod_x_reg;
    assign fmag_y = f1_prod_y_reg[47] ? (~f1_prod_y_reg + 48'd1) : f1_prod_y_reg;

    always_comb begin
        fdiv_side_in.pos_x  = f1_pos_x_reg;
        fdiv_side_in.pos_y  = f1_pos_y_reg;
        fdiv_side_in.vel_x  = f1_vel_x_reg;
        fdiv_side_in.vel_y  = f1_vel_y_reg;
        fdiv_side_in.pinned = f1_pinned_reg;
        fdiv_side_in.neg_x  = f1_prod_x_reg[47];
        fdiv_side_in.neg_y  = f1_prod_y_reg[47];
    end

    logic                              fdiv_valid;
    logic [pes_pkg::FdivNumW-1:0]      fdiv_quo_x, fdiv_quo_y;
    pes_pkg::fdiv_side_t               fdiv_side;

    pes_fdiv u_fdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f1_valid_reg),
        .in_num_x  (fmag_x[46:8]),
        .in_num_y  (fmag_y[46:8]),
        .in_den    (f1_mass_reg),
        .in_side   (fdiv_side_in),
        .out_valid (fdiv_valid),
        .out_quo_x (fdiv_quo_x),
        .out_quo_y (fdiv_quo_y),
        .out_side  (fdiv_side)
    );

    logic                              mot_valid;
    logic [pes_pkg::SqrtInW-1:0]       mot_mag2;
    logic [pes_pkg::LimSqW-1:0]        mot_lim2;
    pes_pkg::sqrt_side_t               mot_side;

    pes_motion u_motion (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .time_step      (time_step_reg),
        .floor_level    (floor_level_reg),
        .bounce_damping (bounce_damping_reg),
        .speed_limit    (speed_limit_reg),
        .in_valid       (fdiv_valid),
        .in_quo_x       (fdiv_quo_x),
        .in_quo_y       (fdiv_quo_y),
        .in_side        (fdiv_side),
        .out_valid      (mot_valid),
        .out_mag2       (mot_mag2),
        .out_lim2       (mot_lim2),
        .out_side       (mot_side)
    );

    logic                              sqrt_valid;
    logic [pes_pkg::SqrtOutW-1:0]      sqrt_root;
    logic                              sqrt_limited;
    pes_pkg::sqrt_side_t               sqrt_side;

    pes_isqrt u_isqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (mot_valid),
        .in_mag2     (mot_mag2),
        .in_lim2     (mot_lim2),
        .in_side     (mot_side),
        .out_valid   (sqrt_valid),
        .out_root    (sqrt_root),
        .out_limited (sqrt_limited),
        .out_side    (sqrt_side)
    );

    logic                              ldiv_valid;
    logic [pes_pkg::LdivNumW-1:0]      ldiv_quo_x, ldiv_quo_y;
    pes_pkg::ldiv_side_t               ldiv_side;

    pes_ldiv u_ldiv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (sqrt_valid),
        .in_root    (sqrt_root),
        .in_limited (sqrt_limited),
        .in_side    (sqrt_side),
        .out_valid  (ldiv_valid),
        .out_quo_x  (ldiv_quo_x),
        .out_quo_y  (ldiv_quo_y),
        .out_side   (ldiv_side)
    );

    // rescaled velocity gets its sign back
    pes_pkg::word_t vlim_x, vlim_y;
    assign vlim_x = ldiv_side.neg_x ? -$signed({1'b0, ldiv_quo_x}) : $signed({1'b0, ldiv_quo_x});
    assign vlim_y = ldiv_side.neg_y ? -$signed({1'b0, ldiv_quo_y}) : $signed({1'b0, ldiv_quo_y});

    // output register
    pes_pkg::word_t m_new_pos_x_reg, m_new_pos_y_reg, m_new_vel_x_reg, m_new_vel_y_reg;
    logic           out_pinned_reg, out_hit_reg, out_limited_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ldiv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_new_pos_x_reg <= ldiv_side.pos_x;
            m_new_pos_y_reg <= ldiv_side.pos_y;
            m_new_vel_x_reg <= ldiv_side.limited ? vlim_x : ldiv_side.vel_x;
            m_new_vel_y_reg <= ldiv_side.limited ? vlim_y : ldiv_side.vel_y;
            out_pinned_reg  <= ldiv_side.pinned;
            out_hit_reg     <= ldiv_side.hit;
            out_limited_reg <= ldiv_side.limited;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_pos_x = m_new_pos_x_reg;
    assign m_new_pos_y = m_new_pos_y_reg;
    assign m_new_vel_x = m_new_vel_x_reg;
    assign m_new_vel_y = m_new_vel_y_reg;

    // checks
    `PES_ASSERT_IMPL(a_pinned_untouched, aclk, aresetn, m_valid_reg && out_pinned_reg, !out_hit_reg && !out_limited_reg)
    `PES_ASSERT_IMPL(a_bounce_upward, aclk, aresetn, m_valid_reg && out_hit_reg && !out_limited_reg, m_new_vel_y_reg <= 0)
    `PES_ASSERT_NEXT(a_reset_empties, aclk, !aresetn, !m_valid_reg)

endmodule

`default_nettype wire

// File: dv/tb_particle_euler_step.sv
// tb_particle_euler_step.sv: self-checking testbench for particle_euler_step
// depends on pes_pkg and the particle_euler_step rtl; a directed table, then random
// particles under several register settings, checked against a built-in predictor or typed values
`default_nettype none

module tb_particle_euler_step;

    // index that hits no register, writes there must be dropped
    localparam logic [pes_pkg::CfgIdxW-1:0] REG_NONE = 3'd7;
    localparam int PIPE_DRAIN = 130;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 110;

    typedef struct {
        pes_pkg::word_t pos_x, pos_y, vel_x, vel_y, force_x, force_y;
        logic [15:0]    mass;
        logic           pinned;
    } particle_t;

    typedef struct {
        pes_pkg::word_t pos_x, pos_y, vel_x, vel_y;
    } motion_t;

    typedef struct {
        particle_t p;
        bit        typed;
        motion_t   res;
    } table_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [pes_pkg::CfgIdxW-1:0]   cfg_index;
    logic [31:0]                   cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    pes_pkg::word_t                s_pos_x, s_pos_y, s_vel_x, s_vel_y, s_force_x, s_force_y;
    logic [pes_pkg::MassW-1:0]     s_mass;
    logic                          s_pinned;
    logic                          m_valid;
    logic                          m_ready;
    pes_pkg::word_t                m_new_pos_x, m_new_pos_y, m_new_vel_x, m_new_vel_y;

    // predictor copy of the registers
    logic [15:0]        step_reg;
    logic signed [31:0] floor_reg;
    logic [15:0]        damp_reg;
    logic [30:0]        limit_reg;

    motion_t    expected_motion[$];
    int         error_count;
    table_row_t directed_rows[$];
    int         burst_left;

    particle_euler_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_vel_x(s_vel_x), .s_vel_y(s_vel_y),
        .s_force_x(s_force_x), .s_force_y(s_force_y), .s_mass(s_mass),
        .s_pinned(s_pinned),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_pos_x(m_new_pos_x), .m_new_pos_y(m_new_pos_y),
        .m_new_vel_x(m_new_vel_x), .m_new_vel_y(m_new_vel_y)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // one semi-implicit euler step with floor bounce and speed clamp
    function automatic motion_t euler_step(particle_t p);
        longint px, py, vx, vy, dt, div, n, lim;
        longint unsigned mag2, lim2;
        motion_t r;
        px = p.pos_x; py = p.pos_y; vx = p.vel_x; vy = p.vel_y;
        if (!p.pinned) begin
            dt  = longint'(step_reg);
            div = (p.mass == 0) ? 256 : longint'(p.mass) * 256;
            vx = clamp32(vx + (longint'(p.force_x) * dt) / div);
            vy = clamp32(vy + (longint'(p.force_y) * dt) / div);
            px = clamp32(px + (vx * dt) / 65536);
            py = clamp32(py + (vy * dt) / 65536);
            if (py > longint'(floor_reg)) begin
                if (vy > 0) vy = -vy;
                py = floor_reg;
                vx = (vx * longint'(damp_reg)) / 65536;
                vy = (vy * longint'(damp_reg)) / 65536;
            end
            mag2 = longint'(vx * vx) + longint'(vy * vy);
            lim  = longint'(limit_reg);
            lim2 = lim * lim;
            if (mag2 > lim2) begin
                n  = longint'(int_sqrt(mag2));
                vx = (vx * lim) / n;
                vy = (vy * lim) / n;
            end
        end
        r.pos_x = px[31:0]; r.pos_y = py[31:0];
        r.vel_x = vx[31:0]; r.vel_y = vy[31:0];
        return r;
    endfunction

    // register write, mirrored into the predictor
    task automatic write_reg(logic [pes_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            pes_pkg::REG_TIME_STEP:      step_reg  = data[15:0];
            pes_pkg::REG_FLOOR_LEVEL:    floor_reg = data;
            pes_pkg::REG_BOUNCE_DAMPING: damp_reg  = data[15:0];
            pes_pkg::REG_SPEED_LIMIT:    limit_reg = data[30:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_all(logic [15:0] ts, logic [31:0] fl, logic [15:0] dmp,
                             logic [31:0] lim);
        write_reg(pes_pkg::REG_TIME_STEP, {16'hffff, ts});
        write_reg(pes_pkg::REG_FLOOR_LEVEL, fl);
        write_reg(pes_pkg::REG_BOUNCE_DAMPING, {$urandom} & 32'hffff0000 | {16'h0000, dmp});
        write_reg(pes_pkg::REG_SPEED_LIMIT, lim);
        write_reg(REG_NONE, $urandom);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // hold one transaction until accepted, then maybe open a gap
    task automatic send_particle(particle_t p);
        int gap;
        s_valid   <= 1'b1;
        s_pos_x   <= p.pos_x;   s_pos_y   <= p.pos_y;
        s_vel_x   <= p.vel_x;   s_vel_y   <= p.vel_y;
        s_force_x <= p.force_x; s_force_y <= p.force_y;
        s_mass    <= p.mass;    s_pinned  <= p.pinned;
        do @(posedge aclk); while (!s_ready);
        expected_motion.push_back(euler_step(p));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 20);
            burst_left = $urandom_range(0, 40);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_motion.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    function automatic pes_pkg::word_t rand_word();
        return pes_pkg::word_t'($urandom);
    endfunction

    // mostly plausible particles, some near the floor, some full-range noise
    function automatic particle_t random_particle();
        particle_t p;
        int kind;
        kind = $urandom_range(0, 9);
        p.pinned = ($urandom_range(0, 7) == 0);
        if (kind < 3) begin
            p.pos_x = rand_word(); p.pos_y = rand_word();
            p.vel_x = rand_word(); p.vel_y = rand_word();
            p.force_x = rand_word(); p.force_y = rand_word();
            p.mass = 16'($urandom);
        end else begin
            p.pos_x = $signed($urandom_range(0, 32'h07ff_ffff)) - 32'sh0400_0000;
            p.pos_y = (kind < 6) ? floor_reg + $signed($urandom_range(0, 32'h0020_0000))
                                 - 32'sh0010_0000
                                 : $signed($urandom_range(0, 32'h07ff_ffff)) - 32'sh0400_0000;
            p.vel_x = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            p.vel_y = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            p.force_x = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
            p.force_y = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
            p.mass = 16'($urandom_range(0, 65535));
        end
        return p;
    endfunction

    function automatic particle_t mk(pes_pkg::word_t px, pes_pkg::word_t py,
                                     pes_pkg::word_t vx, pes_pkg::word_t vy,
                                     pes_pkg::word_t fx, pes_pkg::word_t fy,
                                     logic [15:0] m, logic pin);
        particle_t p;
        p.pos_x = px; p.pos_y = py; p.vel_x = vx; p.vel_y = vy;
        p.force_x = fx; p.force_y = fy; p.mass = m; p.pinned = pin;
        return p;
    endfunction

    function automatic void add_row(particle_t p, bit typed, motion_t res);
        table_row_t r;
        r.p = p; r.typed = typed; r.res = res;
        directed_rows.push_back(r);
    endfunction

    // result checker and receiver stall pattern
    int rx_cycle;
    always @(posedge aclk) begin
        motion_t e;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_cycle <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_motion.size() == 0) begin
                    $display("%0t: unexpected result pos %0d,%0d vel %0d,%0d", $time,
                             m_new_pos_x, m_new_pos_y, m_new_vel_x, m_new_vel_y);
                    error_count++;
                end else begin
                    e = expected_motion.pop_front();
                    if (e.pos_x !== m_new_pos_x || e.pos_y !== m_new_pos_y ||
                        e.vel_x !== m_new_vel_x || e.vel_y !== m_new_vel_y) begin
                        $display("%0t: expected pos %0d,%0d vel %0d,%0d got pos %0d,%0d vel %0d,%0d",
                                 $time, e.pos_x, e.pos_y, e.vel_x, e.vel_y,
                                 m_new_pos_x, m_new_pos_y, m_new_vel_x, m_new_vel_y);
                        error_count++;
                    end
                end
            end
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle / 300) % 3)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // stimulus
    initial begin
        motion_t z, pin_hi, pin_lo;
        particle_t p;
        pes_pkg::word_t wmax, wmin;
        wmax = 32'sh7fff_ffff;
        wmin = 32'sh8000_0000;
        error_count = 0;
        burst_left = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 1'b0;
        s_pos_x = '0; s_pos_y = '0; s_vel_x = '0; s_vel_y = '0;
        s_force_x = '0; s_force_y = '0; s_mass = '0; s_pinned = 1'b0;
        step_reg = pes_pkg::TIME_STEP_RST; floor_reg = pes_pkg::FLOOR_LEVEL_RST;
        damp_reg = pes_pkg::BOUNCE_DAMPING_RST; limit_reg = pes_pkg::SPEED_LIMIT_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table under the reset register values
        z = '{0, 0, 0, 0};
        pin_hi = '{wmax, wmax, wmin, wmin};
        pin_lo = '{wmin, wmin, wmax, wmax};
        add_row(mk(wmax, wmax, wmin, wmin, wmax, wmax, 16'd0, 1'b1), 1, pin_hi);
        add_row(mk(wmin, wmin, wmax, wmax, wmin, wmin, 16'hffff, 1'b1), 1, pin_lo);
        add_row(mk(0, 0, 0, 0, 0, 0, 16'd256, 1'b0), 1, z);
        add_row(mk(0, 0, 0, 0, wmax, wmin, 16'd0, 1'b0), 0, z);
        add_row(mk(0, 0, 0, 0, wmin, wmax, 16'hffff, 1'b0), 0, z);
        add_row(mk(0, wmax, 0, wmin, 0, 0, 16'd256, 1'b0), 0, z);
        add_row(mk(0, wmax, 32'sd655360, 32'sd6553600, 0, 0, 16'd256, 1'b0), 0, z);
        add_row(mk(0, 0, 32'sd131072000, 0, 0, 0, 16'd256, 1'b0), 0, z);
        add_row(mk(0, 0, 32'sd65536000, 0, 0, 0, 16'd256, 1'b0), 0, z);
        add_row(mk(0, 0, wmax, wmax, wmax, wmax, 16'd1, 1'b0), 0, z);
        add_row(mk(wmax, 0, wmax, 0, wmax, 0, 16'd1, 1'b0), 0, z);
        add_row(mk(wmin, 0, wmin, 0, wmin, 0, 16'd1, 1'b0), 0, z);
        add_row(mk(0, 0, 32'sd65536000, -32'sd65536000, 0, 0, 16'd256, 1'b0), 0, z);
        add_row(mk(32'sd100, 32'sd39256000, -32'sd300, 32'sd9000000, 32'sd5,
                   -32'sd7, 16'd3, 1'b0), 0, z);
        foreach (directed_rows[i]) begin
            send_particle(directed_rows[i].p);
            // typed rows replace the predicted value just queued
            if (directed_rows[i].typed) begin
                void'(expected_motion.pop_back());
                expected_motion.push_back(directed_rows[i].res);
            end
        end

        // random particles under a sequence of register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: write_all(pes_pkg::TIME_STEP_RST, pes_pkg::FLOOR_LEVEL_RST,
                             pes_pkg::BOUNCE_DAMPING_RST, 32'(pes_pkg::SPEED_LIMIT_RST));
                1: write_all(16'd0, pes_pkg::FLOOR_LEVEL_RST, pes_pkg::BOUNCE_DAMPING_RST,
                             32'(pes_pkg::SPEED_LIMIT_RST));
                2: write_all(16'hffff, 32'h7fff_ffff, 16'd0, 32'h7fff_ffff);
                3: write_all(16'd1, 32'h8000_0000, 16'hffff, 32'd0);
                4: write_all(16'hffff, 32'd0, 16'hffff, 32'hffff_ffff);
                5: write_all(16'd1, 32'h7fff_ffff, 16'd0, 32'h8000_0000);
                default: write_all(16'($urandom), $urandom_range(0, 32'h0800_0000),
                                   16'($urandom), $urandom_range(0, 32'h1000_0000));
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                p = random_particle();
                send_particle(p);
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/pes_pkg.sv
hw/rtl/pes_fdiv.sv
hw/rtl/pes_motion.sv
hw/rtl/pes_isqrt.sv
hw/rtl/pes_ldiv.sv
hw/rtl/particle_euler_step.sv
dv/tb_particle_euler_step.sv
